FILE: hdl/cbsb_pkg.sv
`timescale 1ns / 1ps
package cbsb_pkg;

	localparam int COORD_BITS_DEF = 32;
	// shared multiplier operand width (signed)
	localparam int MUL_W = 33;
	// fraction bits of the curve parameter t
	localparam int T_FRAC = 30;
	localparam int LIN_FACTOR = 10000;
	localparam int SQRT_STEPS = 31;
	localparam int DIV_STEPS = 30;

	typedef enum logic {
		OP_SQRT,
		OP_DIV
	} root_op_t;

	typedef struct packed {
		logic start;
		root_op_t op;
	} root_req_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_ABC1,
		ST_ABC2,
		ST_NORM,
		ST_D1,
		ST_D2,
		ST_D3,
		ST_SQRT,
		ST_LIN1,
		ST_LIN2,
		ST_ROOT,
		ST_DIV,
		ST_LOAD,
		ST_L1,
		ST_L2,
		ST_L3,
		ST_GROW,
		ST_AXNEXT,
		ST_ANCHOR,
		ST_OUT
	} state_t;

endpackage

FILE: hdl/cbsb_mul.sv
`timescale 1ns / 1ps
module cbsb_mul (
	input  logic                                     clk,
	input  logic signed [cbsb_pkg::MUL_W-1:0]        a,
	input  logic signed [cbsb_pkg::MUL_W-1:0]        b,
	output logic signed [2*cbsb_pkg::MUL_W-1:0]      prod_q
);

	// one registered product per cycle
	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

endmodule

FILE: hdl/cbsb_root.sv
`timescale 1ns / 1ps
module cbsb_root (
	input  logic                clk,
	input  logic                arst_n,
	input  cbsb_pkg::root_req_t req,
	input  logic [63:0]         radicand,
	input  logic [31:0]         dividend,
	input  logic [31:0]         divisor,
	output logic                done,
	output logic [31:0]         res
);

	// shared shift/subtract unit: two radicand bits or one quotient bit a cycle
	logic [63:0] n_q, r_q, bit_q;
	logic [4:0]  cnt_q;
	logic        busy_q, done_q;
	cbsb_pkg::root_op_t op_q;

	logic [63:0] x, y;
	logic [64:0] diff;
	logic        ge;

	always_comb begin
		if (op_q == cbsb_pkg::OP_SQRT) begin
			x = n_q;
			y = r_q + bit_q;
		end else begin
			x = {n_q[62:0], 1'b0};
			y = {32'd0, divisor};
		end
		diff = {1'b0, x} - {1'b0, y};
		ge = !diff[64];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			op_q   <= cbsb_pkg::OP_SQRT;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				op_q   <= req.op;
				cnt_q  <= (req.op == cbsb_pkg::OP_SQRT) ?
					5'(cbsb_pkg::SQRT_STEPS - 1) : 5'(cbsb_pkg::DIV_STEPS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			r_q   <= '0;
			bit_q <= 64'd1 << (2 * (cbsb_pkg::SQRT_STEPS - 1));
			n_q   <= (req.op == cbsb_pkg::OP_SQRT) ? radicand : {32'd0, dividend};
		end else if (busy_q) begin
			if (op_q == cbsb_pkg::OP_SQRT) begin
				if (ge) begin
					n_q <= diff[63:0];
					r_q <= (r_q >> 1) + bit_q;
				end else begin
					r_q <= r_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end else begin
				n_q <= ge ? diff[63:0] : x;
				r_q <= {r_q[62:0], ge};
			end
		end
	end

	assign done = done_q;
	assign res  = r_q[31:0];

endmodule

FILE: hdl/cbsb_core.sv
`timescale 1ns / 1ps
module cbsb_core #(
	parameter int COORD_BITS = cbsb_pkg::COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         busy,
	input  logic signed [COORD_BITS-1:0] point_x,
	input  logic signed [COORD_BITS-1:0] point_y,
	input  logic signed [COORD_BITS-1:0] point_radius,
	input  logic signed [COORD_BITS-1:0] in_ctrl_x,
	input  logic signed [COORD_BITS-1:0] in_ctrl_y,
	input  logic signed [COORD_BITS-1:0] in_ctrl_radius,
	input  logic signed [COORD_BITS-1:0] out_ctrl_x,
	input  logic signed [COORD_BITS-1:0] out_ctrl_y,
	input  logic signed [COORD_BITS-1:0] out_ctrl_radius,
	input  logic                         last_node,
	output logic                         res_valid,
	input  logic                         res_take,
	output logic signed [COORD_BITS-1:0] box_min_x,
	output logic signed [COORD_BITS-1:0] box_min_y,
	output logic signed [COORD_BITS-1:0] box_max_x,
	output logic signed [COORD_BITS-1:0] box_max_y
);

	localparam int CB = COORD_BITS;
	localparam int WE = (CB + 4 > 32) ? CB + 4 : 32;
	localparam int LW = CB + 1;
	localparam int MW = cbsb_pkg::MUL_W;
	localparam logic signed [WE-1:0] NPOS = WE'(64'd1 << cbsb_pkg::T_FRAC);
	localparam logic signed [WE-1:0] NNEG = -NPOS;
	localparam logic signed [CB-1:0] CMAX = {1'b0, {(CB-1){1'b1}}};
	localparam logic signed [CB-1:0] CMIN = {1'b1, {(CB-1){1'b0}}};

	function automatic logic signed [CB-1:0] sat(input logic signed [LW-1:0] v);
		logic signed [CB-1:0] o;
		if (v[LW-1] != v[CB-1])
			o = v[LW-1] ? CMIN : CMAX;
		else
			o = v[CB-1:0];
		return o;
	endfunction

	cbsb_pkg::state_t st_q, st_d;

	logic first_q, last_q, axis_q, ridx_q, lin_q;
	logic [1:0] ch_q;
	logic [2:0] step_q;

	logic signed [CB-1:0] pa_q [3];
	logic signed [CB-1:0] po_q [3];
	logic signed [CB-1:0] ci_q [3];
	logic signed [CB-1:0] pt_q [3];
	logic signed [CB-1:0] co_q [3];
	logic signed [CB-1:0] box_q [4];
	logic signed [CB-1:0] w0_q, w1_q, w2_q, w3_q;
	logic signed [CB-1:0] px_q, py_q, pr_q;

	logic signed [WE-1:0] a_q, b_q, c_q, e_q, f_q;
	logic signed [63:0]   bb_q;
	logic [30:0]          s_q;
	logic [29:0]          t_q;
	logic [31:0]          acc_q;

	logic accept;
	logic [1:0] chsel;
	logic signed [CB-1:0] c0, c1, c2, c3;
	logic norm_ok;
	logic signed [30:0] an31, bn31, cn31;
	logic [30:0] an_mag;
	logic signed [MW-1:0] mul_a, mul_b;
	logic signed [2*MW-1:0] prod_q;
	logic signed [63:0] dsc;
	logic signed [33:0] sb, num, den;
	logic [33:0] sbm, num_m, den_m;
	logic root_ok;
	cbsb_pkg::root_req_t rreq;
	logic root_done;
	logic [31:0] root_res;
	logic signed [CB-1:0] la, lb, lres;
	logic signed [LW-1:0] ld, lres_w;
	logic [LW-1:0] lm;
	logic [63:0] lm64, r64;
	logic lneg;
	logic signed [CB-1:0] ex, ey, er, lx, ly, hx, hy;

	assign accept = in_valid && (st_q == cbsb_pkg::ST_IDLE);
	assign busy   = (st_q != cbsb_pkg::ST_IDLE);

	// channel select for control point reads
	assign chsel = (st_q == cbsb_pkg::ST_LOAD) ? ch_q : {1'b0, axis_q};
	always_comb begin
		case (chsel)
			2'd1: begin
				c0 = pa_q[1]; c1 = po_q[1]; c2 = ci_q[1]; c3 = pt_q[1];
			end
			2'd2: begin
				c0 = pa_q[2]; c1 = po_q[2]; c2 = ci_q[2]; c3 = pt_q[2];
			end
			default: begin
				c0 = pa_q[0]; c1 = po_q[0]; c2 = ci_q[0]; c3 = pt_q[0];
			end
		endcase
	end

	assign norm_ok = (a_q < NPOS) && (a_q > NNEG) && (b_q < NPOS) && (b_q > NNEG)
		&& (c_q < NPOS) && (c_q > NNEG);
	assign an31 = a_q[30:0];
	assign bn31 = b_q[30:0];
	assign cn31 = c_q[30:0];
	assign an_mag = an31[30] ? 31'(-an31) : an31;

	assign dsc = bb_q - prod_q[63:0];

	assign sb  = $signed({3'b000, s_q}) - 34'(bn31);
	assign sbm = sb[33] ? 34'(-sb) : sb;

	// candidate root: numerator and divisor
	always_comb begin
		if (lin_q) begin
			num = -34'(cn31);
			den = 34'(bn31) <<< 1;
		end else begin
			num = ridx_q ? (-$signed({3'b000, s_q}) - 34'(bn31)) : sb;
			den = 34'(an31);
		end
		num_m = num[33] ? 34'(-num) : num;
		den_m = den[33] ? 34'(-den) : den;
		root_ok = (num != '0) && (den != '0) && (num[33] == den[33]) && (num_m < den_m);
	end

	// lerp operands per de Casteljau step
	always_comb begin
		case (step_q)
			3'd1, 3'd4: begin la = w1_q; lb = w2_q; end
			3'd2:       begin la = w2_q; lb = w3_q; end
			default:    begin la = w0_q; lb = w1_q; end
		endcase
		ld   = LW'(lb) - LW'(la);
		lneg = ld[LW-1];
		lm   = lneg ? LW'(-ld) : ld;
		lm64 = 64'(lm);
		r64  = {prod_q[61:0], 2'b00} + {32'd0, acc_q};
		lres_w = lneg ? (LW'(la) - $signed(r64[LW-1:0]))
			: (LW'(la) + $signed(r64[LW-1:0]));
		lres = lres_w[CB-1:0];
	end

	// shared multiplier operands
	always_comb begin
		case (st_q)
			cbsb_pkg::ST_D1: begin
				mul_a = MW'(bn31); mul_b = MW'(bn31);
			end
			cbsb_pkg::ST_D2: begin
				mul_a = MW'(an31); mul_b = MW'(cn31);
			end
			cbsb_pkg::ST_LIN1: begin
				mul_a = $signed({2'b00, an_mag});
				mul_b = MW'(cbsb_pkg::LIN_FACTOR);
			end
			cbsb_pkg::ST_L1: begin
				mul_a = $signed({1'b0, lm64[31:0]});
				mul_b = $signed({3'b000, t_q});
			end
			cbsb_pkg::ST_L2: begin
				mul_a = $signed({1'b0, lm64[63:32]});
				mul_b = $signed({3'b000, t_q});
			end
			default: begin
				mul_a = '0; mul_b = '0;
			end
		endcase
	end

	cbsb_mul u_mul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	always_comb begin
		rreq.start = 1'b0;
		rreq.op    = cbsb_pkg::OP_SQRT;
		if (st_q == cbsb_pkg::ST_D3 && !dsc[63]) begin
			rreq.start = 1'b1;
		end else if (st_q == cbsb_pkg::ST_ROOT && root_ok) begin
			rreq.start = 1'b1;
			rreq.op    = cbsb_pkg::OP_DIV;
		end
	end

	cbsb_root u_root (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (rreq),
		.radicand (dsc),
		.dividend (num_m[31:0]),
		.divisor  (den_m[31:0]),
		.done     (root_done),
		.res      (root_res)
	);

	// box growth operands
	always_comb begin
		if (st_q == cbsb_pkg::ST_GROW) begin
			ex = px_q; ey = py_q; er = pr_q;
		end else begin
			ex = pt_q[0]; ey = pt_q[1]; er = pt_q[2];
		end
		lx = sat(LW'(ex) - LW'(er));
		ly = sat(LW'(ey) - LW'(er));
		hx = sat(LW'(ex) + LW'(er));
		hy = sat(LW'(ey) + LW'(er));
	end

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			cbsb_pkg::ST_IDLE:
				if (accept) st_d = first_q ? cbsb_pkg::ST_CLEAR : cbsb_pkg::ST_ABC1;
			cbsb_pkg::ST_CLEAR:  st_d = cbsb_pkg::ST_ANCHOR;
			cbsb_pkg::ST_ABC1:   st_d = cbsb_pkg::ST_ABC2;
			cbsb_pkg::ST_ABC2:   st_d = cbsb_pkg::ST_NORM;
			cbsb_pkg::ST_NORM:   if (norm_ok) st_d = cbsb_pkg::ST_D1;
			cbsb_pkg::ST_D1:     st_d = cbsb_pkg::ST_D2;
			cbsb_pkg::ST_D2:     st_d = cbsb_pkg::ST_D3;
			cbsb_pkg::ST_D3:     st_d = dsc[63] ? cbsb_pkg::ST_AXNEXT : cbsb_pkg::ST_SQRT;
			cbsb_pkg::ST_SQRT:   if (root_done) st_d = cbsb_pkg::ST_LIN1;
			cbsb_pkg::ST_LIN1:   st_d = cbsb_pkg::ST_LIN2;
			cbsb_pkg::ST_LIN2:   st_d = cbsb_pkg::ST_ROOT;
			cbsb_pkg::ST_ROOT:
				if (root_ok) st_d = cbsb_pkg::ST_DIV;
				else if (lin_q || ridx_q) st_d = cbsb_pkg::ST_AXNEXT;
			cbsb_pkg::ST_DIV:    if (root_done) st_d = cbsb_pkg::ST_LOAD;
			cbsb_pkg::ST_LOAD:   st_d = cbsb_pkg::ST_L1;
			cbsb_pkg::ST_L1:     st_d = cbsb_pkg::ST_L2;
			cbsb_pkg::ST_L2:     st_d = cbsb_pkg::ST_L3;
			cbsb_pkg::ST_L3:
				if (step_q == 3'd5)
					st_d = (ch_q == 2'd2) ? cbsb_pkg::ST_GROW : cbsb_pkg::ST_LOAD;
				else
					st_d = cbsb_pkg::ST_L1;
			cbsb_pkg::ST_GROW:
				st_d = (lin_q || ridx_q) ? cbsb_pkg::ST_AXNEXT : cbsb_pkg::ST_ROOT;
			cbsb_pkg::ST_AXNEXT: st_d = axis_q ? cbsb_pkg::ST_ANCHOR : cbsb_pkg::ST_ABC1;
			cbsb_pkg::ST_ANCHOR: st_d = last_q ? cbsb_pkg::ST_OUT : cbsb_pkg::ST_IDLE;
			cbsb_pkg::ST_OUT:    if (res_take) st_d = cbsb_pkg::ST_IDLE;
			default:             st_d = cbsb_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= cbsb_pkg::ST_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	// spline state: previous node, box, first flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b1;
			for (int i = 0; i < 3; i++) begin
				pa_q[i] <= '0;
				po_q[i] <= '0;
			end
			box_q[0] <= CMAX;
			box_q[1] <= CMAX;
			box_q[2] <= CMIN;
			box_q[3] <= CMIN;
		end else begin
			case (st_q)
				cbsb_pkg::ST_CLEAR: begin
					box_q[0] <= CMAX;
					box_q[1] <= CMAX;
					box_q[2] <= CMIN;
					box_q[3] <= CMIN;
				end
				cbsb_pkg::ST_GROW, cbsb_pkg::ST_ANCHOR: begin
					if (lx < box_q[0]) box_q[0] <= lx;
					if (ly < box_q[1]) box_q[1] <= ly;
					if (hx > box_q[2]) box_q[2] <= hx;
					if (hy > box_q[3]) box_q[3] <= hy;
					if (st_q == cbsb_pkg::ST_ANCHOR) begin
						for (int i = 0; i < 3; i++) begin
							pa_q[i] <= pt_q[i];
							po_q[i] <= co_q[i];
						end
						if (!last_q) first_q <= 1'b0;
					end
				end
				cbsb_pkg::ST_OUT:
					if (res_take) first_q <= 1'b1;
				default: ;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (st_q)
			cbsb_pkg::ST_IDLE: begin
				if (accept) begin
					pt_q[0] <= point_x;
					pt_q[1] <= point_y;
					pt_q[2] <= point_radius;
					ci_q[0] <= in_ctrl_x;
					ci_q[1] <= in_ctrl_y;
					ci_q[2] <= in_ctrl_radius;
					co_q[0] <= out_ctrl_x;
					co_q[1] <= out_ctrl_y;
					co_q[2] <= out_ctrl_radius;
					last_q  <= last_node;
					axis_q  <= 1'b0;
				end
			end
			cbsb_pkg::ST_ABC1: begin
				e_q <= WE'(c3) - WE'(c0);
				f_q <= WE'(c1) - WE'(c2);
				b_q <= WE'(c0) - (WE'(c1) <<< 1) + WE'(c2);
				c_q <= WE'(c1) - WE'(c0);
			end
			cbsb_pkg::ST_ABC2:
				a_q <= e_q + f_q + (f_q <<< 1);
			cbsb_pkg::ST_NORM: begin
				if (!norm_ok) begin
					a_q <= a_q >>> 1;
					b_q <= b_q >>> 1;
					c_q <= c_q >>> 1;
				end
			end
			cbsb_pkg::ST_D2:
				bb_q <= prod_q[63:0];
			cbsb_pkg::ST_SQRT:
				if (root_done) s_q <= root_res[30:0];
			cbsb_pkg::ST_LIN2: begin
				lin_q  <= $unsigned({32'd0, sbm}) > $unsigned(prod_q);
				ridx_q <= 1'b0;
			end
			cbsb_pkg::ST_ROOT:
				if (!root_ok) ridx_q <= 1'b1;
			cbsb_pkg::ST_DIV: begin
				if (root_done) begin
					t_q  <= root_res[29:0];
					ch_q <= 2'd0;
				end
			end
			cbsb_pkg::ST_LOAD: begin
				w0_q   <= c0;
				w1_q   <= c1;
				w2_q   <= c2;
				w3_q   <= c3;
				step_q <= 3'd0;
			end
			cbsb_pkg::ST_L2:
				acc_q <= prod_q[61:30];
			cbsb_pkg::ST_L3: begin
				case (step_q)
					3'd1, 3'd4: w1_q <= lres;
					3'd2:       w2_q <= lres;
					default:    w0_q <= lres;
				endcase
				step_q <= step_q + 3'd1;
				if (step_q == 3'd5) begin
					case (ch_q)
						2'd1:    py_q <= lres;
						2'd2:    pr_q <= lres;
						default: px_q <= lres;
					endcase
					ch_q <= ch_q + 2'd1;
				end
			end
			cbsb_pkg::ST_GROW:
				ridx_q <= 1'b1;
			cbsb_pkg::ST_AXNEXT:
				axis_q <= 1'b1;
			default: ;
		endcase
	end

	assign res_valid = (st_q == cbsb_pkg::ST_OUT);
	assign box_min_x = box_q[0];
	assign box_min_y = box_q[1];
	assign box_max_x = box_q[2];
	assign box_max_y = box_q[3];

`ifndef SYNTHESIS
	a_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		root_done |-> (st_q == cbsb_pkg::ST_SQRT || st_q == cbsb_pkg::ST_DIV))
		else $error("root unit finished outside a wait state");
	a_norm: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == cbsb_pkg::ST_D1) |-> norm_ok)
		else $error("coefficients not normalised before discriminant");
	a_first: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && first_q) |=> (st_q == cbsb_pkg::ST_CLEAR))
		else $error("first node did not clear the box");
	a_res_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> last_q)
		else $error("box offered on a node not marked last");
`endif

endmodule

FILE: hdl/cubic_bezier_spline_bounds.sv
`timescale 1ns / 1ps
// Bounding box of a cubic Bezier spline, signed fixed point, saturating.
// Input channel (in_valid / in_stall): one beat per node, carrying anchor,
// incoming and outgoing control points, each with a radius, and last_node.
// The beat is taken when in_valid is high and in_stall low. in_stall is high
// while a node is being worked on; one node is processed at a time.
// Output channel (out_valid / out_stall): one beat with min/max x/y on every
// node marked last. The box sits in an output register, so the next node is
// taken while it waits; a stalled box holds its value until taken.
// A first node only clears the box, adds its anchor circle and is stored.
// A later node runs per axis the coefficient steps, up to 5 normalising
// shifts for 32-bit words, the discriminant and the square root, then for
// each root inside (0,1) a divide, then a load and 6 lerps for each of x,
// y and radius, and a box update; an axis with a negative discriminant
// skips the root work. The work is serialised on the one shared
// multiplier and the one shift/subtract unit that serves root and
// divide.
// If the box is still waiting on out_stall when another last node finishes,
// the block holds in_stall until the register frees.
// Reset (arst_n low) empties the box, clears the previous node, and marks
// the next node as the first of a spline.
module cubic_bezier_spline_bounds #(
	parameter int COORD_BITS = cbsb_pkg::COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [COORD_BITS-1:0] point_x,
	input  logic signed [COORD_BITS-1:0] point_y,
	input  logic signed [COORD_BITS-1:0] point_radius,
	input  logic signed [COORD_BITS-1:0] in_ctrl_x,
	input  logic signed [COORD_BITS-1:0] in_ctrl_y,
	input  logic signed [COORD_BITS-1:0] in_ctrl_radius,
	input  logic signed [COORD_BITS-1:0] out_ctrl_x,
	input  logic signed [COORD_BITS-1:0] out_ctrl_y,
	input  logic signed [COORD_BITS-1:0] out_ctrl_radius,
	input  logic                         last_node,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [COORD_BITS-1:0] min_x,
	output logic signed [COORD_BITS-1:0] min_y,
	output logic signed [COORD_BITS-1:0] max_x,
	output logic signed [COORD_BITS-1:0] max_y
);

	logic busy, res_valid, res_take;
	logic signed [COORD_BITS-1:0] bmin_x, bmin_y, bmax_x, bmax_y;
	logic out_valid_q;
	logic signed [COORD_BITS-1:0] min_x_q, min_y_q, max_x_q, max_y_q;

	cbsb_core #(
		.COORD_BITS (COORD_BITS)
	) u_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.busy            (busy),
		.point_x         (point_x),
		.point_y         (point_y),
		.point_radius    (point_radius),
		.in_ctrl_x       (in_ctrl_x),
		.in_ctrl_y       (in_ctrl_y),
		.in_ctrl_radius  (in_ctrl_radius),
		.out_ctrl_x      (out_ctrl_x),
		.out_ctrl_y      (out_ctrl_y),
		.out_ctrl_radius (out_ctrl_radius),
		.last_node       (last_node),
		.res_valid       (res_valid),
		.res_take        (res_take),
		.box_min_x       (bmin_x),
		.box_min_y       (bmin_y),
		.box_max_x       (bmax_x),
		.box_max_y       (bmax_y)
	);

	assign in_stall = busy;

	// output register loads when empty or being drained this cycle
	assign res_take = res_valid && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (res_take)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			min_x_q <= bmin_x;
			min_y_q <= bmin_y;
			max_x_q <= bmax_x;
			max_y_q <= bmax_y;
		end
	end

	assign out_valid = out_valid_q;
	assign min_x = min_x_q;
	assign min_y = min_y_q;
	assign max_x = max_x_q;
	assign max_y = max_y_q;

endmodule
